>>> src/somc_pkg.sv
// shared types and constants for the substring one-mismatch check
// no dependencies; used by somc_cmp and the top level
package somc_pkg;

    localparam int CHAR_W = 8;
    localparam int STR_IN_W = 4;
    localparam int POS_IN_W = 12;
    localparam int END_IN_W = 13;
    localparam int REM_W = 13;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [CHAR_W-1:0] char_t;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic valid;
    } cmp_ctrl_t;

    // status from the compare unit back to the sequencer
    typedef struct packed {
        logic over_one;
    } cmp_stat_t;

endpackage

>>> src/somc_ram.sv
// generic memory: one write port, two read ports, registered read data
// no dependencies
module somc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> src/somc_cmp.sv
// shared character compare unit with saturating mismatch counter
// depends on somc_pkg
module somc_cmp (
    input  logic                clk,
    input  logic                rst_n,
    input  somc_pkg::cmp_ctrl_t ctrl,
    input  somc_pkg::char_t     char_a,
    input  somc_pkg::char_t     char_b,
    output somc_pkg::cmp_stat_t stat
);

    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = 2'd0;
        end
        else if (ctrl.valid && (char_a != char_b) && (count_reg != 2'd2))
        begin
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // two mismatches seen: the walk may stop
    assign stat.over_one = (count_reg == 2'd2);

endmodule

>>> src/substring_one_mismatch_check.sv
// substring one-mismatch check: sequencer on somc_pkg, somc_ram and somc_cmp
// load: the position is folded into range one MAX_LENGTH at a time, then the character is written
// query, count = first_end - first_start + 1 >= 1: both starts are folded the same way, then
// count pairs are read and compared and the result is offered; an empty range answers yes and
// a reversed range no; a second mismatch ends the walk as if count stopped there
// reset clears control state; a waiting result holds the next query; memory undefined until loaded
module substring_one_mismatch_check #(
    parameter int NUM_STRINGS = 16,
    parameter int MAX_LENGTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [3:0]  first_string,
    input  logic [11:0] first_start,
    input  logic [12:0] first_end,
    input  logic [3:0]  second_string,
    input  logic [11:0] second_start,
    input  logic [7:0]  char_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        within_one_mismatch
);

    // string index and position widths
    localparam int SW = (NUM_STRINGS > 1) ? $clog2(NUM_STRINGS) : 1;
    localparam int PW = $clog2(MAX_LENGTH);
    localparam int AW = SW + PW;
    localparam int RAW_W = (PW > somc_pkg::POS_IN_W) ? PW : somc_pkg::POS_IN_W;
    localparam logic [RAW_W:0] ML_WIDE = (RAW_W + 1)'(MAX_LENGTH);
    localparam logic [RAW_W-1:0] ML_RAW = ML_WIDE[RAW_W-1:0];
    localparam logic [PW:0] ML_POS = (PW + 1)'(MAX_LENGTH);

    // state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_REDUCE = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // string index folding table, built at elaboration
    typedef logic [SW-1:0] str_tbl_t [16];

    function automatic str_tbl_t make_str_tbl();
        str_tbl_t tbl;
        for (int k = 0; k < 16; k++)
        begin
            tbl[k] = SW'(k % NUM_STRINGS);
        end
        return tbl;
    endfunction

    localparam str_tbl_t STR_TBL = make_str_tbl();

    // position increment with wrap at the string length
    function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
        logic [PW:0] nxt;
        nxt = {1'b0, p} + (PW + 1)'(1);
        if (nxt == ML_POS)
        begin
            return '0;
        end
        return nxt[PW-1:0];
    endfunction

    // control registers
    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rd_valid_reg;
    logic       rd_valid_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // request payload registers
    logic                          op_reg;
    logic [SW-1:0]                 s1_reg;
    logic [SW-1:0]                 s2_reg;
    logic [RAW_W-1:0]              p1_reg;
    logic [RAW_W-1:0]              p1_next;
    logic [RAW_W-1:0]              p2_reg;
    logic [RAW_W-1:0]              p2_next;
    logic [somc_pkg::REM_W-1:0]    rem_reg;
    logic [somc_pkg::REM_W-1:0]    rem_next;
    logic                          neg_reg;
    somc_pkg::char_t               char_reg;
    logic                          result_reg;
    logic                          result_next;
    logic                          out_data_reg;
    logic                          out_data_next;

    // range length from the raw request fields
    logic signed [somc_pkg::REM_W:0] count_in;

    // shared position folding subtractor
    logic             p1_big;
    logic             p2_big;
    logic [RAW_W-1:0] sub_in;
    logic [RAW_W-1:0] sub_out;
    logic             reduce_done;

    // memory and compare unit hookup
    logic                mem_we;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr_a;
    logic [AW-1:0]       raddr_b;
    somc_pkg::char_t     rdata_a;
    somc_pkg::char_t     rdata_b;
    somc_pkg::cmp_ctrl_t cmp_ctrl;
    somc_pkg::cmp_stat_t cmp_stat;
    logic                issue;

    assign count_in = $signed({first_end[12], first_end})
                    - $signed({2'b00, first_start})
                    + (somc_pkg::REM_W + 1)'(1);

    assign p1_big = ({1'b0, p1_reg} >= ML_WIDE);
    assign p2_big = (op_reg == somc_pkg::OP_QUERY) && ({1'b0, p2_reg} >= ML_WIDE);
    assign sub_in = p1_big ? p1_reg : p2_reg;
    assign sub_out = sub_in - ML_RAW;
    assign reduce_done = !p1_big && !p2_big;

    assign in_ready = (state_reg == ST_IDLE);
    assign issue = (state_reg == ST_WALK) && (rem_reg != '0);

    // a load writes once its position is folded into range
    assign mem_we = (state_reg == ST_REDUCE) && reduce_done
                 && (op_reg == somc_pkg::OP_LOAD);
    assign waddr = {s1_reg, p1_reg[PW-1:0]};
    assign raddr_a = {s1_reg, p1_reg[PW-1:0]};
    assign raddr_b = {s2_reg, p2_reg[PW-1:0]};

    assign cmp_ctrl.clear = (state_reg == ST_REDUCE);
    assign cmp_ctrl.valid = rd_valid_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        rd_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        rem_next = rem_reg;
        result_next = result_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    p1_next = RAW_W'(first_start);
                    p2_next = RAW_W'(second_start);
                    rem_next = count_in[somc_pkg::REM_W-1:0];
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                // fold one position per cycle through the shared subtractor
                if (p1_big)
                begin
                    p1_next = sub_out;
                end
                else if (p2_big)
                begin
                    p2_next = sub_out;
                end
                else if (op_reg == somc_pkg::OP_LOAD)
                begin
                    state_next = ST_IDLE;
                end
                else if (neg_reg)
                begin
                    // reversed range
                    result_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (issue)
                begin
                    rd_valid_next = 1'b1;
                    p1_next = RAW_W'(pos_inc(p1_reg[PW-1:0]));
                    p2_next = RAW_W'(pos_inc(p2_reg[PW-1:0]));
                    rem_next = rem_reg - somc_pkg::REM_W'(1);
                end
                if (cmp_stat.over_one)
                begin
                    // second mismatch found, stop early
                    rd_valid_next = 1'b0;
                    result_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else if ((rem_reg == '0) && !rd_valid_reg)
                begin
                    // every pair compared, empty range lands here at once
                    result_next = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = result_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_valid_reg <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= operation;
            s1_reg <= STR_TBL[first_string];
            s2_reg <= STR_TBL[second_string];
            neg_reg <= count_in[somc_pkg::REM_W];
            char_reg <= char_value;
        end
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        rem_reg <= rem_next;
        result_reg <= result_next;
        out_data_reg <= out_data_next;
    end

    somc_ram #(
        .WIDTH(somc_pkg::CHAR_W),
        .DEPTH(1 << AW)
    ) u_text_ram (
        .clk(clk),
        .we(mem_we),
        .waddr(waddr),
        .wdata(char_reg),
        .raddr_a(raddr_a),
        .rdata_a(rdata_a),
        .raddr_b(raddr_b),
        .rdata_b(rdata_b)
    );

    somc_cmp u_cmp (
        .clk(clk),
        .rst_n(rst_n),
        .ctrl(cmp_ctrl),
        .char_a(rdata_a),
        .char_b(rdata_b),
        .stat(cmp_stat)
    );

    assign out_valid = out_valid_reg;
    assign within_one_mismatch = out_data_reg;

    // a new result only comes out of the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish step");

    // walk positions are always folded into the string length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (({1'b0, p1_reg} < ML_WIDE) && ({1'b0, p2_reg} < ML_WIDE)))
        else $error("walk position out of range");

    // read data is only marked valid right after a walk issue
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> ($past(state_reg == ST_WALK) && $past(rem_reg != '0)))
        else $error("compare strobe without a read");

    // a load never writes while a query walk is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (op_reg == somc_pkg::OP_LOAD) && !rd_valid_reg)
        else $error("memory write during a query");

endmodule

>>> tb/tb.sv
// self-checking bench for substring_one_mismatch_check: loads strings, runs
// range comparisons and checks every verdict against an in-bench text mirror
// depends on somc_pkg and substring_one_mismatch_check
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STRINGS = 16;
    localparam int TEXT_LEN = 4096;
    localparam int RANDOM_ITEMS = 550;
    localparam int PAUSE_EVERY = 180;     // sender drains the block this often
    localparam int HOLD_AFTER = 40;       // results seen before the long receiver hold
    localparam int LONG_HOLD = 500;       // cycles of the long receiver hold
    localparam int TAIL_CYCLES = 64;
    localparam longint LIMIT_NS = 20_000_000;

    // one request as queued for the driver
    typedef struct {
        logic                          operation;
        logic [somc_pkg::STR_IN_W-1:0] first_string;
        logic [somc_pkg::POS_IN_W-1:0] first_start;
        logic [somc_pkg::END_IN_W-1:0] first_end;
        logic [somc_pkg::STR_IN_W-1:0] second_string;
        logic [somc_pkg::POS_IN_W-1:0] second_start;
        logic [somc_pkg::CHAR_W-1:0]   char_value;
        bit                            wait_idle;   // hold this request until no verdict is owed
    } req_t;

    // a stretch of text that has been loaded, so a query over it is legal
    typedef struct {
        int str;
        int start;
        int len;
    } region_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          operation = somc_pkg::OP_LOAD;
    logic [somc_pkg::STR_IN_W-1:0] first_string = '0;
    logic [somc_pkg::POS_IN_W-1:0] first_start = '0;
    logic [somc_pkg::END_IN_W-1:0] first_end = '0;
    logic [somc_pkg::STR_IN_W-1:0] second_string = '0;
    logic [somc_pkg::POS_IN_W-1:0] second_start = '0;
    logic [somc_pkg::CHAR_W-1:0]   char_value = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          within_one_mismatch;

    // mirror of the text memory and the verdicts still owed by the block
    logic [somc_pkg::CHAR_W-1:0] text_copy [0:STRINGS*TEXT_LEN-1];
    logic                        expected_verdicts [$];

    req_t    pending_reqs [$];
    req_t    cur_req;
    region_t regions [$];
    bit      pause_next = 1'b0;
    int      queued_reqs = 0;
    int      accepted_reqs = 0;
    int      results_seen = 0;
    int      error_count = 0;

    // sender burst shaping
    int burst_left = 8;
    int gap_left = 0;

    // receiver stall shaping
    int ready_phase = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;

    substring_one_mismatch_check #(
        .NUM_STRINGS (STRINGS),
        .MAX_LENGTH  (TEXT_LEN)
    ) i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .operation           (operation),
        .first_string        (first_string),
        .first_start         (first_start),
        .first_end           (first_end),
        .second_string       (second_string),
        .second_start        (second_start),
        .char_value          (char_value),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .within_one_mismatch (within_one_mismatch)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // verdict prediction: loads update the mirror, queries walk the two
    // ranges pair by pair (positions wrap per string) and stop at the
    // second mismatch
    // ------------------------------------------------------------------
    task automatic predict_verdict(input req_t r);
        int last;
        int span;
        int mism;
        int i;
        int addr_a;
        int addr_b;
        if (r.operation == somc_pkg::OP_LOAD)
        begin
            text_copy[int'(r.first_string) * TEXT_LEN + int'(r.first_start)] = r.char_value;
        end
        else
        begin
            last = $signed(r.first_end);
            span = last - int'(r.first_start) + 1;
            mism = 0;
            // reversed range answers no, empty range walks nothing and answers yes
            if (span < 0)
                mism = 2;
            for (i = 0; i < span && mism < 2; i++)
            begin
                addr_a = int'(r.first_string) * TEXT_LEN + (int'(r.first_start) + i) % TEXT_LEN;
                addr_b = int'(r.second_string) * TEXT_LEN
                         + (int'(r.second_start) + i) % TEXT_LEN;
                if (text_copy[addr_a] != text_copy[addr_b])
                    mism++;
            end
            expected_verdicts.push_back(mism <= 1);
        end
    endtask

    // ------------------------------------------------------------------
    // request queueing; fields a request ignores still get random values
    // ------------------------------------------------------------------
    task automatic queue_request(input req_t r);
        r.wait_idle = pause_next;
        pause_next = 1'b0;
        pending_reqs.push_back(r);
        queued_reqs++;
    endtask

    task automatic queue_load(input int s, input int p, input int c);
        req_t r;
        r.operation = somc_pkg::OP_LOAD;
        r.first_string = 4'(s);
        r.first_start = 12'(p % TEXT_LEN);
        r.first_end = 13'($urandom_range(0, 8191));
        r.second_string = 4'($urandom_range(0, 15));
        r.second_start = 12'($urandom_range(0, 4095));
        r.char_value = 8'(c);
        queue_request(r);
    endtask

    task automatic queue_query(input int s1, input int p1, input int e1,
                               input int s2, input int p2);
        req_t r;
        r.operation = somc_pkg::OP_QUERY;
        r.first_string = 4'(s1);
        r.first_start = 12'(p1);
        r.first_end = e1[somc_pkg::END_IN_W-1:0];
        r.second_string = 4'(s2);
        r.second_start = 12'(p2 % TEXT_LEN);
        r.char_value = 8'($urandom_range(0, 255));
        queue_request(r);
    endtask

    // ------------------------------------------------------------------
    // stimulus: directed corners first, then random load/compare sequences
    // ------------------------------------------------------------------
    initial
    begin
        int k;
        int len;
        int sa;
        int sb;
        int pa;
        int pb;
        int flips;
        int off;
        int n;
        int o;
        int p1;
        int p2;
        int e;
        int pick;
        int idx;
        int random_base;
        region_t ra;
        region_t rb;
        logic [somc_pkg::CHAR_W-1:0] chars [0:63];

        // string 0 starts 00 ff, string 15 holds a5 00 ff across its wrap point
        queue_load(0, 0, 8'h00);
        queue_load(0, 1, 8'hFF);
        queue_load(15, 4095, 8'hA5);
        queue_load(15, 0, 8'h00);
        queue_load(15, 1, 8'hFF);
        queue_load(1, 0, 8'h00);
        queue_load(1, 1, 8'h7E);
        // identical ranges
        queue_query(0, 0, 1, 15, 0);
        // single character at the top of the string, compared with itself
        queue_query(15, 4095, 4095, 15, 4095);
        // second range wraps and holds two mismatches
        queue_query(0, 0, 1, 15, 4095);
        // exactly one mismatch
        queue_query(0, 0, 1, 1, 0);
        queue_query(0, 1, 1, 15, 0);
        // empty ranges: end one below start, including end of -1
        queue_query(0, 0, -1, 15, 4095);
        queue_query(15, 4095, 4094, 0, 0);
        // reversed ranges, down to the most negative end
        queue_query(15, 4095, -4096, 0, 4095);
        queue_query(0, 2, 0, 1, 0);

        // random part; the first request waits for the block to drain
        random_base = queued_reqs;
        pause_next = 1'b1;
        while (queued_reqs - random_base < RANDOM_ITEMS)
        begin
            if ((queued_reqs - random_base) / PAUSE_EVERY
                != (queued_reqs - random_base + 1) / PAUSE_EVERY)
                pause_next = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 4 || regions.size() < 2)
            begin
                // load a fresh stretch and a copy of it with a few flipped
                // characters, then compare the two
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                                   : $urandom_range(1, 16);
                sa = $urandom_range(0, 15);
                sb = ($urandom_range(0, 5) == 0) ? sa : $urandom_range(0, 15);
                pa = $urandom_range(0, TEXT_LEN - len);
                pb = ($urandom_range(0, 3) == 0) ? $urandom_range(TEXT_LEN - len, TEXT_LEN - 1)
                                                 : $urandom_range(0, TEXT_LEN - 1);
                for (k = 0; k < len; k++)
                begin
                    chars[k] = 8'($urandom_range(0, 255));
                    queue_load(sa, pa + k, chars[k]);
                end
                flips = $urandom_range(0, 3);
                for (k = 0; k < flips; k++)
                begin
                    off = $urandom_range(0, len - 1);
                    chars[off] = chars[off] ^ 8'($urandom_range(1, 255));
                end
                for (k = 0; k < len; k++)
                    queue_load(sb, pb + k, chars[k]);
                regions.push_back('{sa, pa, len});
                regions.push_back('{sb, pb, len});
                queue_query(sa, pa, pa + len - 1, sb, pb);
            end
            else if (pick < 7)
            begin
                // sub-range of a loaded pair at a common offset, mostly near matches
                idx = 2 * $urandom_range(0, regions.size() / 2 - 1);
                ra = regions[idx];
                rb = regions[idx + 1];
                n = $urandom_range(1, ra.len);
                o = $urandom_range(0, ra.len - n);
                queue_query(ra.str, ra.start + o, ra.start + o + n - 1, rb.str, rb.start + o);
            end
            else if (pick < 9)
            begin
                // any two loaded stretches against each other
                ra = regions[$urandom_range(0, regions.size() - 1)];
                rb = regions[$urandom_range(0, regions.size() - 1)];
                n = $urandom_range(1, (ra.len < rb.len) ? ra.len : rb.len);
                p1 = (ra.start + $urandom_range(0, ra.len - n)) % TEXT_LEN;
                p2 = rb.start + $urandom_range(0, rb.len - n);
                if (p1 + n - 1 < TEXT_LEN)
                    queue_query(ra.str, p1, p1 + n - 1, rb.str, p2);
            end
            else
            begin
                // noise: stray loads, empty and reversed ranges
                case ($urandom_range(0, 2))
                    0: queue_load($urandom_range(0, 15), $urandom_range(0, 4095),
                                  $urandom_range(0, 255));
                    1:
                    begin
                        p1 = $urandom_range(0, 4095);
                        queue_query($urandom_range(0, 15), p1, p1 - 1,
                                    $urandom_range(0, 15), $urandom_range(0, 4095));
                    end
                    default:
                    begin
                        p1 = $urandom_range(1, 4095);
                        e = int'($urandom_range(0, p1 + 4094)) - 4096;
                        queue_query($urandom_range(0, 15), p1, e,
                                    $urandom_range(0, 15), $urandom_range(0, 4095));
                    end
                endcase
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // everything accepted, every verdict back, then let the block settle
        while (accepted_reqs != queued_reqs)
            @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // request driver: bursts of random length with random gaps; valid and
    // payload only move once the current request is taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        req_t nxt;
        logic taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= somc_pkg::OP_LOAD;
            first_string <= '0;
            first_start <= '0;
            first_end <= '0;
            second_string <= '0;
            second_start <= '0;
            char_value <= '0;
        end
        else
        begin
            taken = in_valid && in_ready;
            if (taken)
            begin
                predict_verdict(cur_req);
                accepted_reqs++;
            end
            if (!in_valid || taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                // a marked request waits until the block owes nothing
                else if (pending_reqs.size() != 0
                         && (!pending_reqs[0].wait_idle || expected_verdicts.size() == 0))
                begin
                    nxt = pending_reqs.pop_front();
                    cur_req = nxt;
                    in_valid <= 1'b1;
                    operation <= nxt.operation;
                    first_string <= nxt.first_string;
                    first_start <= nxt.first_start;
                    first_end <= nxt.first_end;
                    second_string <= nxt.second_string;
                    second_start <= nxt.second_start;
                    char_value <= nxt.char_value;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: steady stretches, random stalls, and one long hold that
    // backs the block up into its input
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_receiver
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (!long_hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            ready_phase = (ready_phase + 1) % 96;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (ready_phase < 32)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // ------------------------------------------------------------------
    // result monitor: each verdict against the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : verdict_monitor
        logic owed;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_verdicts.size() == 0)
            begin
                $error("within_one_mismatch: expected no result, actual %0b",
                       within_one_mismatch);
                error_count++;
            end
            else
            begin
                owed = expected_verdicts.pop_front();
                if (within_one_mismatch !== owed)
                begin
                    $error("within_one_mismatch: expected %0b, actual %0b",
                           owed, within_one_mismatch);
                    error_count++;
                end
            end
        end
    end

endmodule
